FILE: sv/frq_pkg.sv
// frq_pkg: shared types and constants for the frame ring queue.
// Used by frq_ctrl, frq_datapath and frame_ring_queue; no dependencies.
package frq_pkg;

    localparam int DEF_QUEUE_DEPTH = 8;
    localparam int DEF_FRAME_BYTES = 64;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int KIND_W = 3;
    localparam int HELD_W = 4;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_OK   = 3'd0,
        KIND_PUSH_FULL = 3'd1,
        KIND_POP_BYTE  = 3'd2,
        KIND_EMPTY     = 3'd3,
        KIND_ZERO_LEN  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_LEN,
        ST_POP_BYTE
    } state_t;

    typedef struct packed {
        logic push;
        logic pop_empty;
        logic pop_start;
        logic pop_zero;
        logic pop_byte;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic len_zero;
        logic byte_last;
    } stat_t;

endpackage

FILE: sv/frame_ring_queue.sv
// frame_ring_queue: ring queue of whole frames, top level.
// A push result is registered on the output in the cycle after the frame's last beat.
// Push beats are taken one per cycle while the output register is free.
// A pop runs through accept, slot length fetch, then one byte per cycle from the frame store
// read port while the output register is free; inputs are held off until the run ends.
// Reset clears slot pointers, frame count and push tracking; the stores are not cleared.
module frame_ring_queue
    import frq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int FRAME_BYTES = DEF_FRAME_BYTES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic              last_in,
    input  logic              empty_frame,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [KIND_W-1:0] kind,
    output logic [BYTE_W-1:0] byte_out,
    output logic [LEN_W-1:0]  frame_len,
    output logic              last_out,
    output logic [HELD_W-1:0] frames_held
);

    cmd_t  cmd;
    stat_t stat;

    frq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    frq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .byte_in     (byte_in),
        .last_in     (last_in),
        .empty_frame (empty_frame),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .byte_out    (byte_out),
        .frame_len   (frame_len),
        .last_out    (last_out),
        .frames_held (frames_held)
    );

endmodule

FILE: sv/frq_ctrl.sv
// frq_ctrl: controller state machine of the frame ring queue.
// Depends on frq_pkg; drives commands to frq_datapath from its status.
module frq_ctrl
    import frq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  func,
    input  stat_t stat,
    output logic  in_stall,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && stat.out_free && func == FUNC_POP && !stat.count_zero)
                begin
                    state_next = ST_POP_LEN;
                end
            end
            ST_POP_LEN:
            begin
                if (!stat.len_zero)
                begin
                    state_next = ST_POP_BYTE;
                end
                else if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP_BYTE:
            begin
                if (stat.out_free && stat.byte_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = !stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    if (func == FUNC_PUSH)
                    begin
                        cmd.push = 1'b1;
                    end
                    else if (stat.count_zero)
                    begin
                        cmd.pop_empty = 1'b1;
                    end
                    else
                    begin
                        cmd.pop_start = 1'b1;
                    end
                end
            end
            ST_POP_LEN:
            begin
                cmd.pop_zero = stat.len_zero && stat.out_free;
            end
            ST_POP_BYTE:
            begin
                cmd.pop_byte = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall)
        else $error("input taken during a pop run");

    a_pop_enters_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_start |=> state_reg == ST_POP_LEN)
        else $error("pop start did not fetch length");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one command at once");

endmodule

FILE: sv/frq_datapath.sv
// frq_datapath: frame and length stores, slot pointers, push tracking and
// the output register of the frame ring queue. Depends on frq_pkg.
module frq_datapath
    import frq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int FRAME_BYTES = DEF_FRAME_BYTES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic              last_in,
    input  logic              empty_frame,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [KIND_W-1:0] kind,
    output logic [BYTE_W-1:0] byte_out,
    output logic [LEN_W-1:0]  frame_len,
    output logic              last_out,
    output logic [HELD_W-1:0] frames_held
);

    localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
    localparam int POS_W     = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = QUEUE_DEPTH << POS_W;
    localparam int ADDR_W    = SLOT_W + POS_W;

    logic [BYTE_W-1:0] frame_mem [MEM_DEPTH];
    logic [LEN_W-1:0]  len_mem   [QUEUE_DEPTH];

    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] read_slot_reg, read_slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              in_frame_reg, in_frame_next;
    logic              dropping_reg, dropping_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  rd_pos_reg, rd_pos_next;
    logic [BYTE_W-1:0] rd_data_reg;
    logic [LEN_W-1:0]  len_rd_reg;

    logic              out_valid_reg, out_valid_next;
    kind_t             out_kind_reg, out_kind_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic              out_last_reg, out_last_next;
    logic [CNT_W-1:0]  out_held_reg, out_held_next;

    logic              first;
    logic              drop;
    logic [LEN_W-1:0]  pos_cur;
    logic              store;
    logic [LEN_W-1:0]  pos_inc;
    logic              frame_end;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              len_we;
    logic              load;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        r = (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
        return r;
    endfunction

    assign stat.out_free   = !out_valid_reg || !out_stall;
    assign stat.count_zero = (count_reg == '0);
    assign stat.len_zero   = (len_rd_reg == '0);
    assign stat.byte_last  = ((rd_pos_reg + LEN_W'(1)) == len_rd_reg);

    // push tracking
    assign first     = !in_frame_reg;
    assign drop      = first ? (count_reg >= CNT_W'(QUEUE_DEPTH)) : dropping_reg;
    assign pos_cur   = first ? '0 : pos_reg;
    assign store     = !empty_frame && (pos_cur < LEN_W'(FRAME_BYTES));
    assign pos_inc   = pos_cur + LEN_W'(store);
    assign frame_end = last_in || empty_frame;
    assign mem_we    = cmd.push && store && !drop;
    assign len_we    = cmd.push && frame_end && !drop;
    assign wr_addr   = {write_slot_reg, pos_cur[POS_W-1:0]};
    assign rd_addr   = {read_slot_reg, rd_pos_next[POS_W-1:0]};

    always_comb
    begin
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        count_next      = count_reg;
        in_frame_next   = in_frame_reg;
        dropping_next   = dropping_reg;
        pos_next        = pos_reg;
        rd_pos_next     = rd_pos_reg;

        if (cmd.push)
        begin
            if (frame_end)
            begin
                in_frame_next = 1'b0;
                dropping_next = 1'b0;
                pos_next      = '0;
                if (!drop)
                begin
                    write_slot_next = slot_inc(write_slot_reg);
                    count_next      = count_reg + 1'b1;
                end
            end
            else
            begin
                in_frame_next = 1'b1;
                dropping_next = drop;
                pos_next      = pos_inc;
            end
        end
        if (cmd.pop_start)
        begin
            count_next  = count_reg - 1'b1;
            rd_pos_next = '0;
        end
        if (cmd.pop_zero || (cmd.pop_byte && stat.byte_last))
        begin
            read_slot_next = slot_inc(read_slot_reg);
        end
        if (cmd.pop_byte)
        begin
            rd_pos_next = rd_pos_reg + LEN_W'(1);
        end
    end

    // output register
    assign load = (cmd.push && frame_end) || cmd.pop_empty || cmd.pop_zero || cmd.pop_byte;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;
        out_held_next  = out_held_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = '0;
            out_len_next   = '0;
            out_last_next  = 1'b1;
            out_held_next  = count_next;
            priority if (cmd.push)
            begin
                out_kind_next = drop ? KIND_PUSH_FULL : KIND_PUSH_OK;
                out_len_next  = drop ? '0 : pos_inc;
                out_last_next = 1'b0;
            end
            else if (cmd.pop_empty)
            begin
                out_kind_next = KIND_EMPTY;
            end
            else if (cmd.pop_zero)
            begin
                out_kind_next = KIND_ZERO_LEN;
            end
            else
            begin
                out_kind_next = KIND_POP_BYTE;
                out_byte_next = rd_data_reg;
                out_len_next  = len_rd_reg;
                out_last_next = stat.byte_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            count_reg      <= '0;
            in_frame_reg   <= 1'b0;
            dropping_reg   <= 1'b0;
            pos_reg        <= '0;
            rd_pos_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            count_reg      <= count_next;
            in_frame_reg   <= in_frame_next;
            dropping_reg   <= dropping_next;
            pos_reg        <= pos_next;
            rd_pos_reg     <= rd_pos_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
        out_held_reg <= out_held_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[wr_addr] <= byte_in;
        end
        rd_data_reg <= frame_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[write_slot_reg] <= pos_inc;
        end
        len_rd_reg <= len_mem[read_slot_reg];
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign byte_out    = out_byte_reg;
    assign frame_len   = out_len_reg;
    assign last_out    = out_last_reg;
    assign frames_held = HELD_W'(out_held_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("frame count beyond queue depth");

    a_pop_in_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_byte |-> rd_pos_reg < len_rd_reg)
        else $error("pop read past frame length");

    a_slot_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop_byte && stat.byte_last) |=> read_slot_reg != $past(read_slot_reg))
        else $error("read slot not advanced at end of pop");

endmodule

FILE: verif/frame_ring_queue_test.sv
// frame_ring_queue_test: self-checking bench for the frame ring queue.
// Needs frq_pkg and frame_ring_queue. It runs a directed table, then random frames and pops,
// and checks every output beat against the table's expected beat or an in-bench predictor.
module frame_ring_queue_test;
    import frq_pkg::*;

    localparam int QD        = DEF_QUEUE_DEPTH;
    localparam int FB        = DEF_FRAME_BYTES;
    localparam int RAND_BEATS = 36;
    localparam int LIMIT     = 500000;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              last;
        logic [HELD_W-1:0] held;
    } out_beat_t;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              empty;
        logic [7:0]        reps;
        logic              fixed;
        out_beat_t         want;
    } stim_row_t;

    localparam out_beat_t NO_WANT = '0;

    localparam stim_row_t SCRIPT [19] = '{
        '{FUNC_POP,  8'h5A, 1'b1, 1'b1, 8'd1,  1'b1, '{KIND_EMPTY,     8'h00, 7'd0,  1'b1, 4'd0}},
        '{FUNC_PUSH, 8'hFF, 1'b0, 1'b1, 8'd1,  1'b1, '{KIND_PUSH_OK,   8'h00, 7'd0,  1'b0, 4'd1}},
        '{FUNC_PUSH, 8'h00, 1'b1, 1'b0, 8'd1,  1'b1, '{KIND_PUSH_OK,   8'h00, 7'd1,  1'b0, 4'd2}},
        '{FUNC_PUSH, 8'hFF, 1'b0, 1'b0, 8'd1,  1'b0, NO_WANT},
        '{FUNC_PUSH, 8'h80, 1'b0, 1'b0, 8'd1,  1'b0, NO_WANT},
        '{FUNC_PUSH, 8'h33, 1'b0, 1'b1, 8'd1,  1'b0, NO_WANT},
        '{FUNC_POP,  8'h00, 1'b0, 1'b0, 8'd1,  1'b1, '{KIND_ZERO_LEN,  8'h00, 7'd0,  1'b1, 4'd2}},
        '{FUNC_POP,  8'hFF, 1'b1, 1'b0, 8'd1,  1'b1, '{KIND_POP_BYTE,  8'h00, 7'd1,  1'b1, 4'd1}},
        '{FUNC_POP,  8'h00, 1'b0, 1'b1, 8'd1,  1'b0, NO_WANT},
        // overlong frame: 64 stored, the rest discarded
        '{FUNC_PUSH, 8'h01, 1'b0, 1'b0, 8'd64, 1'b0, NO_WANT},
        '{FUNC_PUSH, 8'hC0, 1'b0, 1'b0, 8'd3,  1'b0, NO_WANT},
        '{FUNC_PUSH, 8'h7F, 1'b1, 1'b0, 8'd1,  1'b1, '{KIND_PUSH_OK,   8'h00, 7'd64, 1'b0, 4'd1}},
        '{FUNC_PUSH, 8'h10, 1'b1, 1'b0, 8'd7,  1'b0, NO_WANT},
        // frame opened on a full queue, pop in the middle of it
        '{FUNC_PUSH, 8'hAA, 1'b0, 1'b0, 8'd1,  1'b0, NO_WANT},
        '{FUNC_POP,  8'h00, 1'b0, 1'b0, 8'd1,  1'b0, NO_WANT},
        '{FUNC_PUSH, 8'h55, 1'b1, 1'b0, 8'd1,  1'b1, '{KIND_PUSH_FULL, 8'h00, 7'd0,  1'b0, 4'd7}},
        '{FUNC_PUSH, 8'hE7, 1'b1, 1'b0, 8'd1,  1'b1, '{KIND_PUSH_OK,   8'h00, 7'd1,  1'b0, 4'd8}},
        '{FUNC_PUSH, 8'h00, 1'b1, 1'b1, 8'd1,  1'b1, '{KIND_PUSH_FULL, 8'h00, 7'd0,  1'b0, 4'd8}},
        '{FUNC_POP,  8'h00, 1'b0, 1'b0, 8'd9,  1'b0, NO_WANT}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              func = FUNC_PUSH;
    logic [BYTE_W-1:0] byte_in = '0;
    logic              last_in = 1'b0;
    logic              empty_frame = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] byte_out;
    logic [LEN_W-1:0]  frame_len;
    logic              last_out;
    logic [HELD_W-1:0] frames_held;

    frame_ring_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .byte_in     (byte_in),
        .last_in     (last_in),
        .empty_frame (empty_frame),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .byte_out    (byte_out),
        .frame_len   (frame_len),
        .last_out    (last_out),
        .frames_held (frames_held)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    logic [BYTE_W-1:0] frame_mem [QD*FB];
    logic [LEN_W-1:0]  slot_len [QD];
    int unsigned       wr_slot = 0;
    int unsigned       rd_slot = 0;
    int unsigned       held_frames = 0;
    int unsigned       fill_pos = 0;
    bit                frame_open = 1'b0;
    bit                discarding = 1'b0;

    out_beat_t fresh_beats [$];
    out_beat_t want_beats [$];

    int  mismatches = 0;
    int  beats_sent = 0;
    int  cycles = 0;
    int  calm_beats = 0;
    bit  in_random = 1'b0;
    bit  quiet = 1'b0;
    bit  long_hold_done = 1'b0;

    function automatic void predict_queue(input logic op, input logic [BYTE_W-1:0] data,
                                          input logic last, input logic empty);
        int unsigned n;
        int unsigned slot;
        fresh_beats.delete();
        if (op == FUNC_PUSH)
        begin
            if (!frame_open)
            begin
                frame_open = 1'b1;
                fill_pos   = 0;
                discarding = (held_frames >= QD);
            end
            if (!empty && fill_pos < FB)
            begin
                if (!discarding)
                    frame_mem[wr_slot*FB + fill_pos] = data;
                fill_pos++;
            end
            if (last || empty)
            begin
                frame_open = 1'b0;
                if (discarding)
                begin
                    discarding = 1'b0;
                    fresh_beats.push_back('{KIND_PUSH_FULL, 8'h00, 7'd0, 1'b0,
                                            HELD_W'(held_frames)});
                end
                else
                begin
                    slot_len[wr_slot] = LEN_W'(fill_pos);
                    wr_slot = (wr_slot + 1) % QD;
                    held_frames++;
                    fresh_beats.push_back('{KIND_PUSH_OK, 8'h00, LEN_W'(fill_pos), 1'b0,
                                            HELD_W'(held_frames)});
                end
                fill_pos = 0;
            end
        end
        else if (held_frames == 0)
        begin
            fresh_beats.push_back('{KIND_EMPTY, 8'h00, 7'd0, 1'b1, 4'd0});
        end
        else
        begin
            slot = rd_slot;
            n = slot_len[slot];
            rd_slot = (rd_slot + 1) % QD;
            held_frames--;
            if (n == 0)
                fresh_beats.push_back('{KIND_ZERO_LEN, 8'h00, 7'd0, 1'b1,
                                        HELD_W'(held_frames)});
            else
                for (int i = 0; i < n; i++)
                    fresh_beats.push_back('{KIND_POP_BYTE, frame_mem[slot*FB + i], LEN_W'(n),
                                            (i + 1 == n), HELD_W'(held_frames)});
        end
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_beat(input logic op, input logic [BYTE_W-1:0] data, input logic last,
                             input logic empty, input logic fixed, input out_beat_t want);
        int gap;
        gap = 0;
        if (!quiet)
        begin
            if (calm_beats > 0)
                calm_beats--;
            else if ($urandom_range(0, 19) == 0)
                calm_beats = $urandom_range(10, 40);
            else if ($urandom_range(0, 4) == 0)
                gap = $urandom_range(1, 17);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        func        <= op;
        byte_in     <= data;
        last_in     <= last;
        empty_frame <= empty;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_queue(op, data, last, empty);
        if (fixed)
            want_beats.push_back(want);
        else
            foreach (fresh_beats[i])
                want_beats.push_back(fresh_beats[i]);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches < 60)
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        out_beat_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (want_beats.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat kind=%0d byte=%0h len=%0d last=%0b held=%0d",
                         $time, kind, byte_out, frame_len, last_out, frames_held);
            end
            else
            begin
                w = want_beats.pop_front();
                check_field("kind", w.kind, kind);
                check_field("byte_out", w.data, byte_out);
                check_field("frame_len", w.len, frame_len);
                check_field("last_out", w.last, last_out);
                check_field("frames_held", w.held, frames_held);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : receiver
        int hold;
        int calm;
        hold = 0;
        calm = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold == 0 && in_random && !long_hold_done)
            begin
                // long hold-off while the sender keeps going
                hold = 300;
                long_hold_done = 1'b1;
            end
            else if (hold == 0 && calm == 0 && !quiet)
            begin
                if ($urandom_range(0, 9) == 0)
                    hold = $urandom_range(1, 17);
                else if ($urandom_range(0, 29) == 0)
                    calm = $urandom_range(20, 80);
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (calm > 0)
                    calm--;
            end
        end
    end

    initial
    begin : sender
        stim_row_t row;
        int        start;
        int        pop_bias;
        int        flen;
        bit        close_empty;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < $size(SCRIPT); r++)
        begin
            row = SCRIPT[r];
            for (int k = 0; k < row.reps; k++)
                send_beat(row.op, row.data + BYTE_W'(k), row.last, row.empty, row.fixed,
                          row.want);
        end

        in_random = 1'b1;
        start = beats_sent;
        pop_bias = 1;
        while (beats_sent < start + RAND_BEATS)
        begin
            if (beats_sent >= start + RAND_BEATS - 12)
                quiet = 1'b1;
            if ($urandom_range(0, 9) == 0)
                pop_bias = $urandom_range(0, 3);
            if ($urandom_range(0, 3) < pop_bias)
            begin
                send_beat(FUNC_POP, BYTE_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, NO_WANT);
            end
            else
            begin
                case ($urandom_range(0, 15))
                    0:       flen = 0;
                    1:       flen = $urandom_range(9, 16);
                    default: flen = $urandom_range(1, 8);
                endcase
                close_empty = (flen == 0) || ($urandom_range(0, 5) == 0);
                for (int i = 0; i < flen; i++)
                begin
                    if ($urandom_range(0, 11) == 0)
                        send_beat(FUNC_POP, BYTE_W'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0,
                                  NO_WANT);
                    send_beat(FUNC_PUSH, BYTE_W'($urandom_range(0, 255)),
                              (i == flen - 1) && !close_empty, 1'b0, 1'b0, NO_WANT);
                end
                if (close_empty)
                    send_beat(FUNC_PUSH, BYTE_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'b1, 1'b0, NO_WANT);
            end
        end
        in_valid <= 1'b0;

        while (want_beats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && want_beats.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
